@@ hw/rtl/lsb_stego_embed_extract_defines.svh @@
// Assertion macros shared by the LSB stego block.
`ifndef LSB_STEGO_EMBED_EXTRACT_DEFINES_SVH
`define LSB_STEGO_EMBED_EXTRACT_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define LSE_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define LSE_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/lse_pkg.sv @@
// Package for the LSB stego block: types, codes and chunk decode helpers.
package lse_pkg;

  // Trailer bytes appended to the extracted size.
  localparam int unsigned EXT_BYTES = 5;
  localparam logic [32:0] EXT_BYTES_W = 33'(EXT_BYTES);

  // Configuration register indexes.
  localparam logic [1:0] REG_BITS_SELECT  = 2'd0;
  localparam logic [1:0] REG_DIRECTION    = 2'd1;
  localparam logic [1:0] REG_CARRIER_SIZE = 2'd2;

  // Bits-per-carrier selector codes.
  localparam logic [1:0] SEL_ONE        = 2'd0;
  localparam logic [1:0] SEL_TWO        = 2'd1;
  localparam logic [1:0] SEL_FOUR       = 2'd2;
  localparam logic [1:0] SEL_FOUR_ALIAS = 2'd3;

  // Direction codes.
  localparam logic DIR_EMBED   = 1'b0;
  localparam logic DIR_EXTRACT = 1'b1;

  typedef enum logic [1:0] {
    KIND_STEGO   = 2'd0,
    KIND_HEADER  = 2'd1,
    KIND_PAYLOAD = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_DONE    = 2'd2,
    PH_ERROR   = 2'd3
  } phase_t;

  typedef struct packed {
    logic [1:0]  bits_select;
    logic        direction;
    logic [31:0] carrier_size;
  } cfg_t;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_t      byte_kind;
    logic       is_last;
    logic       size_error;
  } res_t;

  // Number of low carrier bits used per byte.
  function automatic logic [2:0] chunk_width(input logic [1:0] sel);
    logic [2:0] w;
    unique case (sel) inside
      SEL_ONE:                  w = 3'd1;
      SEL_TWO:                  w = 3'd2;
      SEL_FOUR, SEL_FOUR_ALIAS: w = 3'd4;
      default:                  w = 3'd4;
    endcase
    return w;
  endfunction

  // Mask of the low carrier bits used per byte.
  function automatic logic [7:0] chunk_mask(input logic [1:0] sel);
    logic [7:0] m;
    unique case (sel) inside
      SEL_ONE:                  m = 8'h01;
      SEL_TWO:                  m = 8'h03;
      SEL_FOUR, SEL_FOUR_ALIAS: m = 8'h0F;
      default:                  m = 8'h0F;
    endcase
    return m;
  endfunction

endpackage

@@ hw/rtl/lse_ifs.sv @@
// Handshake interfaces for the carrier, result and configuration channels.
interface lse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] cover_byte;
  logic [7:0] payload_byte;
  logic       start_of_image;

  modport source (output valid, cover_byte, payload_byte, start_of_image,
                  input ready);
  modport sink (input valid, cover_byte, payload_byte, start_of_image,
                output ready);
endinterface

interface lse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] byte_kind;
  logic       is_last;
  logic       size_error;

  modport source (output valid, out_byte, byte_kind, is_last, size_error,
                  input ready);
  modport sink (input valid, out_byte, byte_kind, is_last, size_error,
                output ready);
endinterface

interface lse_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/lse_cfg_regs.sv @@
// Configuration register file: bits_select, direction, carrier_size.
module lse_cfg_regs
  import lse_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  lse_cfg_if.sink   cfg,
  output cfg_t      regs
);

  logic wr;

  // Writes are always taken; unknown indexes are dropped
  assign cfg.ready = 1'b1;
  assign wr        = cfg.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (wr) begin
      unique case (cfg.index)
        REG_BITS_SELECT:  regs.bits_select  <= cfg.data[1:0];
        REG_DIRECTION:    regs.direction    <= cfg.data[0];
        REG_CARRIER_SIZE: regs.carrier_size <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/lse_core.sv @@
// Embed/extract datapath: stream state and per-word result computation.
module lse_core
  import lse_pkg::*;
`include "lsb_stego_embed_extract_defines.svh"
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       regs,
  input  logic       fire,
  input  logic [7:0] cover_byte,
  input  logic [7:0] payload_byte,
  input  logic       start_of_image,
  output logic       push,
  output res_t       res
);

  // Stream state
  logic [2:0]  chunk_offset, chunk_offset_next;
  logic [7:0]  held_payload, held_payload_next;
  logic [7:0]  gather_byte, gather_byte_next;
  logic [2:0]  header_count, header_count_next;
  logic [31:0] size_value, size_value_next;
  logic [32:0] bytes_left, bytes_left_next;
  phase_t      phase, phase_next;

  // Working values
  logic [2:0]  n;
  logic [7:0]  mask;
  logic [2:0]  off_b;
  logic [7:0]  gath_b;
  logic [2:0]  hc_b;
  logic [31:0] size_b;
  logic [32:0] bl_b;
  phase_t      ph_b;
  logic [3:0]  off_sum;
  logic        complete;
  logic [3:0]  rshift;
  logic [7:0]  held_sel;
  logic [7:0]  held_shl;
  logic [7:0]  chunk;
  logic [7:0]  gbits;
  logic [7:0]  gath_new;
  logic [31:0] size_new;
  logic [2:0]  hc_new;
  logic [32:0] bl_sum;
  logic [32:0] bl_dec;

  // Restart on start of image applies before the word is processed
  assign n        = chunk_width(regs.bits_select);
  assign mask     = chunk_mask(regs.bits_select);
  assign off_b    = start_of_image ? 3'd0 : chunk_offset;
  assign gath_b   = start_of_image ? 8'd0 : gather_byte;
  assign hc_b     = start_of_image ? 3'd0 : header_count;
  assign size_b   = start_of_image ? 32'd0 : size_value;
  assign bl_b     = start_of_image ? 33'd0 : bytes_left;
  assign ph_b     = start_of_image ? PH_HEADER : phase;
  assign off_sum  = {1'b0, off_b} + {1'b0, n};
  assign complete = off_sum[3];
  assign rshift   = 4'd8 - {1'b0, n};

  // Embed: take the next chunk of the held byte, MSB first
  assign held_sel = (off_b == 3'd0) ? payload_byte : held_payload;
  assign held_shl = held_sel << off_b;
  assign chunk    = held_shl >> rshift;

  // Extract: place the carrier chunk below the bits gathered so far
  assign gbits    = (cover_byte & mask) << rshift;
  assign gath_new = gath_b | (gbits >> off_b);
  assign size_new = {size_b[23:0], gath_new};
  assign hc_new   = hc_b + 3'd1;
  assign bl_sum   = {1'b0, size_new} + EXT_BYTES_W;
  assign bl_dec   = bl_b - 33'd1;

  // Next state and result
  always_comb begin
    chunk_offset_next = chunk_offset;
    held_payload_next = held_payload;
    gather_byte_next  = gather_byte;
    header_count_next = header_count;
    size_value_next   = size_value;
    bytes_left_next   = bytes_left;
    phase_next        = phase;
    push              = 1'b0;
    res               = '0;
    if (fire) begin
      gather_byte_next  = gath_b;
      header_count_next = hc_b;
      size_value_next   = size_b;
      bytes_left_next   = bl_b;
      phase_next        = ph_b;
      if (regs.direction == DIR_EMBED) begin
        held_payload_next = held_sel;
        chunk_offset_next = complete ? 3'd0 : off_sum[2:0];
        push              = 1'b1;
        res.out_byte      = (cover_byte & ~mask) | (chunk & mask);
        res.byte_kind     = KIND_STEGO;
      end else if (!complete) begin
        chunk_offset_next = off_sum[2:0];
        gather_byte_next  = gath_new;
      end else begin
        chunk_offset_next = 3'd0;
        gather_byte_next  = 8'd0;
        unique case (ph_b)
          PH_HEADER: begin
            size_value_next   = size_new;
            header_count_next = hc_new;
            push              = 1'b1;
            res.out_byte      = gath_new;
            res.byte_kind     = KIND_HEADER;
            if (hc_new >= 3'd4) begin
              if (size_new >= regs.carrier_size) begin
                res.size_error = 1'b1;
                phase_next     = PH_ERROR;
              end else begin
                bytes_left_next = bl_sum;
                phase_next      = (bl_sum == 33'd0) ? PH_DONE : PH_PAYLOAD;
              end
            end
          end
          PH_PAYLOAD: begin
            bytes_left_next = bl_dec;
            push            = 1'b1;
            res.out_byte    = gath_new;
            res.byte_kind   = KIND_PAYLOAD;
            res.is_last     = (bl_dec == 33'd0);
            if (bl_dec == 33'd0) begin
              phase_next = PH_DONE;
            end
          end
          PH_DONE, PH_ERROR: ;
        endcase
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_offset <= '0;
      held_payload <= '0;
      gather_byte  <= '0;
      header_count <= '0;
      size_value   <= '0;
      bytes_left   <= '0;
      phase        <= PH_HEADER;
    end else begin
      chunk_offset <= chunk_offset_next;
      held_payload <= held_payload_next;
      gather_byte  <= gather_byte_next;
      header_count <= header_count_next;
      size_value   <= size_value_next;
      bytes_left   <= bytes_left_next;
      phase        <= phase_next;
    end
  end

  // Checks
  `LSE_ASSERT_IMP(a_last_is_payload, clk, rst, push && res.is_last, res.byte_kind == KIND_PAYLOAD, "is_last on non-payload word")
  `LSE_ASSERT_NXT(a_err_to_phase, clk, rst, push && res.size_error, phase == PH_ERROR, "size error did not stop extraction")
  `LSE_ASSERT_IMP(a_payload_left, clk, rst, phase == PH_PAYLOAD, bytes_left != 33'd0, "payload phase with nothing left")
  `LSE_ASSERT_IMP(a_embed_pushes, clk, rst, fire && (regs.direction == DIR_EMBED), push, "embed word gave no result")

endmodule

@@ hw/rtl/lse_out_stage.sv @@
// Result register driving the output channel.
module lse_out_stage
  import lse_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  res_t        res,
  output logic        can_take,
  lse_out_if.source   result
);

  logic valid, valid_next;
  res_t data;

  // Room for a new word when empty or the held word leaves now
  assign can_take   = !valid || result.ready;
  assign valid_next = push ? 1'b1 : (result.ready ? 1'b0 : valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data <= res;
    end
  end

  assign result.valid      = valid;
  assign result.out_byte   = data.out_byte;
  assign result.byte_kind  = data.byte_kind;
  assign result.is_last    = data.is_last;
  assign result.size_error = data.size_error;

endmodule

@@ hw/rtl/lsb_stego_embed_extract.sv @@
// LSB steganography embed/extract block, top level.
//
// Channels: "carrier" takes one carrier byte per word with a payload byte and
// a start_of_image flag; "result" gives stego bytes (embed) or recovered
// header and payload bytes (extract); "cfg" writes bits_select (index 0),
// direction (1) and carrier_size (2) and is always ready; the user must write
// cfg only while idle, which the block does not enforce. Embed gives one
// result word per carrier word. Extract gives one word per completed byte:
// four big-endian size bytes, then size + 5 payload bytes with is_last on the
// final one, or size_error on the fourth header byte and nothing more until
// the next start_of_image. A result is valid in the cycle after its carrier
// word is taken. Throughput: one carrier word per cycle; the single result
// register sets this, and carrier.ready stays high while that register is
// empty or its word is being taken in the same cycle.
// When the receiver stalls, the result word holds and the carrier channel
// stalls with it once the result register is full.
// Reset (rst, synchronous) clears the configuration registers, the stream state
// and the result valid; start_of_image restarts chunk and header parsing.
module lsb_stego_embed_extract
  import lse_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  lse_cfg_if.sink    cfg,
  lse_in_if.sink     carrier,
  lse_out_if.source  result
);

  cfg_t regs;
  logic fire;
  logic push;
  logic can_take;
  res_t res;

  assign carrier.ready = can_take;
  assign fire          = carrier.valid && can_take;

  lse_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  lse_core u_core (
    .clk            (clk),
    .rst            (rst),
    .regs           (regs),
    .fire           (fire),
    .cover_byte     (carrier.cover_byte),
    .payload_byte   (carrier.payload_byte),
    .start_of_image (carrier.start_of_image),
    .push           (push),
    .res            (res)
  );

  lse_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .res      (res),
    .can_take (can_take),
    .result   (result)
  );

endmodule
